>>> sv/ric_pkg.sv
// Shared types, codes and widths for the reference-counted inode cache.
`default_nettype none

package ric_pkg;

    localparam int SLOTS_DEFAULT = 64;
    localparam int IPB_DEFAULT   = 8;

    localparam int DEV_W  = 4;
    localparam int INO_W  = 32;
    localparam int IDX_W  = 6;
    localparam int BLK_W  = 32;
    localparam int OFF_W  = 3;
    localparam int REFS_W = 16;
    localparam int STAT_W = 3;
    localparam int CFG_W  = 32;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 64;

    localparam logic [REFS_W-1:0] REFS_MAX       = '1;
    localparam logic [DEV_W-1:0]  ROOT_DEV_RESET = 4'd0;
    localparam logic [INO_W-1:0]  ROOT_INO_RESET = 32'd2;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } ric_cmd_t;

    typedef enum logic
    {
        CFG_ROOT_DEVICE = 1'b0,
        CFG_ROOT_INODE  = 1'b1
    } ric_cfg_t;

    typedef enum logic [STAT_W-1:0]
    {
        STAT_HIT       = 3'd0,
        STAT_LOADED    = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_RELEASED  = 3'd3,
        STAT_WRITEBACK = 3'd4,
        STAT_BAD_SLOT  = 3'd5
    } ric_status_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_PUT_RD,
        ST_PUT_EVAL,
        ST_DIV,
        ST_RESP
    } ric_state_t;

    typedef struct packed
    {
        logic [DEV_W-1:0]  dev;
        logic [INO_W-1:0]  ino;
        logic [REFS_W-1:0] refs;
        logic              dirty;
    } ric_entry_t;

    localparam int ENTRY_W = $bits(ric_entry_t);

endpackage

`default_nettype wire

>>> sv/ric_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ric_ram #(
    parameter int WIDTH = ric_pkg::ENTRY_W,
    parameter int DEPTH = ric_pkg::SLOTS_DEFAULT,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/ric_div.sv
// Constant divider for the inode location: reciprocal multiply, then quotient and remainder.
`default_nettype none

module ric_div #(
    parameter int DIVISOR = ric_pkg::IPB_DEFAULT,
    localparam int RW = $clog2(DIVISOR) + 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [ric_pkg::INO_W-1:0] dividend,
    output logic                           done,
    output logic      [ric_pkg::INO_W-1:0] quotient,
    output logic      [RW-1:0]             remainder
);

    import ric_pkg::*;

    localparam int SH = INO_W + $clog2(DIVISOR);
    localparam int MW = INO_W + 1;
    localparam int PW = INO_W + MW;
    localparam logic [63:0]   RECIP_FULL = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1)
                                           / 64'(DIVISOR);
    localparam logic [MW-1:0] RECIP      = RECIP_FULL[MW-1:0];
    localparam logic [RW-1:0] DIV_V      = RW'(DIVISOR);

    logic [2:0]       stage_reg;
    logic [INO_W-1:0] k_reg;
    logic [PW-1:0]    prod_reg;
    logic [INO_W-1:0] q_reg;
    logic [RW-1:0]    qd_low;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            k_reg <= dividend;
        end
        prod_reg <= PW'(k_reg) * PW'(RECIP);
        q_reg    <= INO_W'(prod_reg >> SH);
    end

    assign qd_low    = RW'(q_reg[RW-1:0] * DIV_V);
    assign done      = stage_reg[2];
    assign quotient  = q_reg;
    assign remainder = k_reg[RW-1:0] - qd_low;

endmodule

`default_nettype wire

>>> sv/refcounted_inode_cache_unit.sv
// Reference-counted inode cache: slot table, scan sequencer and result register.
//
// Commands arrive on the s_ channel, one beat each; every beat yields exactly one
// result beat on the m_ channel. s_tready is high only while the block is idle,
// so one command is in flight at a time.
// A get scans the slot table from slot 0, one RAM read a cycle, until a hit or
// the end of the table. A miss that claims a slot also runs the reciprocal
// divider that locates the inode on disk (block and offset in the inode table).
// A put reads the named slot and updates it; a slot index beyond the table is
// answered without a table read, and a dirty slot that needs writeback also
// runs the divider. The next command is taken only after the block has returned
// to idle once its result enters the output register, so a new command waits
// for the previous one to finish. The table RAM read port and the scan sequencer set the pace.
// After reset the block sweeps the table clear, one slot a cycle; commands are
// held off until the sweep ends, configuration writes are taken.
// A finished result waits in the output register while m_tready is low; the
// block accepts the next command meanwhile and holds its result until taken.
// Configuration (root device, root inode) is written on the cfg_ channel, always ready;
// the user must write it only while no command is outstanding, the block does not enforce this.
`default_nettype none

module refcounted_inode_cache_unit #(
    parameter int SLOTS            = ric_pkg::SLOTS_DEFAULT,
    parameter int INODES_PER_BLOCK = ric_pkg::IPB_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // device_id[3:0], inode_number[35:4], slot_index[41:36], modified[42],
    // table_block[74:43], zero fill[79:75]
    input  wire logic [ric_pkg::S_TDATA_W-1:0] s_tdata,
    // command[0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // slot_out[5:0], disk_block[37:6], block_offset[40:38], refs_left[56:41],
    // zero fill[63:57]
    output logic      [ric_pkg::M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic      [ric_pkg::STAT_W-1:0]    m_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic                          cfg_index,
    input  wire logic [ric_pkg::CFG_W-1:0]     cfg_data
);

    import ric_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RW = $clog2(INODES_PER_BLOCK) + 1;

    ric_state_t state_reg;
    ric_state_t state_next;

    logic [CW-1:0]     cnt_reg;
    logic              scan_pend_reg;
    logic [SW-1:0]     pend_addr_reg;
    logic              free_found_reg;
    logic [SW-1:0]     free_slot_reg;

    logic [DEV_W-1:0]  dev_reg;
    logic [INO_W-1:0]  ino_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              mod_reg;
    logic [BLK_W-1:0]  table_reg;

    ric_status_t       res_status_reg;
    logic [IDX_W-1:0]  res_slot_reg;
    logic [BLK_W-1:0]  res_blk_reg;
    logic [OFF_W-1:0]  res_off_reg;
    logic [REFS_W-1:0] res_refs_reg;

    logic              m_valid_reg;
    ric_status_t       out_status_reg;
    logic [IDX_W-1:0]  out_slot_reg;
    logic [BLK_W-1:0]  out_blk_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic [REFS_W-1:0] out_refs_reg;

    logic [DEV_W-1:0]  root_dev_reg;
    logic [INO_W-1:0]  root_ino_reg;

    logic [DEV_W-1:0]  s_dev;
    logic [INO_W-1:0]  s_ino;
    logic [IDX_W-1:0]  s_idx;
    logic              s_mod;
    logic [BLK_W-1:0]  s_table;
    logic              s_accept;
    logic              bad_idx;

    logic              ram_we;
    logic [SW-1:0]     ram_waddr;
    ric_entry_t        ram_wdata;
    logic [SW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    ric_entry_t        cur;

    logic              cur_used;
    logic              hit_now;
    logic              free_now;
    logic              scan_end;
    logic              free_any;
    logic [SW-1:0]     free_slot;
    logic [REFS_W-1:0] hit_refs;

    logic [REFS_W-1:0] put_refs_dec;
    logic              put_dirty;
    logic              put_is_root;
    logic [REFS_W-1:0] put_refs_fin;
    logic              put_wdirty;
    logic              put_wb;

    logic              div_start;
    logic [INO_W-1:0]  div_dividend;
    logic              div_done;
    logic [INO_W-1:0]  div_q;
    logic [RW-1:0]     div_rem;

    logic              resp_load;

    assign s_dev   = s_tdata[3:0];
    assign s_ino   = s_tdata[35:4];
    assign s_idx   = s_tdata[41:36];
    assign s_mod   = s_tdata[42];
    assign s_table = s_tdata[74:43];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign bad_idx   = (32'(s_idx) >= 32'(SLOTS));
    assign cfg_ready = 1'b1;
    assign resp_load = (state_reg == ST_RESP) && (!m_valid_reg || m_tready);

    ric_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ric_div #(
        .DIVISOR (INODES_PER_BLOCK)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    always_comb
    begin
        cur       = ric_entry_t'(ram_rdata);
        cur_used  = (cur.refs != '0);
        hit_now   = scan_pend_reg && cur_used && (cur.dev == dev_reg) && (cur.ino == ino_reg);
        free_now  = scan_pend_reg && !cur_used && !free_found_reg;
        scan_end  = scan_pend_reg && (hit_now || (cnt_reg == CW'(SLOTS)));
        free_any  = free_found_reg || free_now;
        free_slot = free_found_reg ? free_slot_reg : pend_addr_reg;
        hit_refs  = (cur.refs == REFS_MAX) ? cur.refs : cur.refs + REFS_W'(1);

        put_refs_dec = cur.refs - REFS_W'(1);
        put_dirty    = cur.dirty | mod_reg;
        put_is_root  = (cur.dev == root_dev_reg) && (cur.ino == root_ino_reg);
        if (put_refs_dec != '0)
        begin
            put_refs_fin = put_refs_dec;
        end
        else
        begin
            put_refs_fin = put_is_root ? REFS_W'(1) : '0;
        end
        put_wdirty = (put_refs_dec != '0) ? put_dirty : 1'b0;
        put_wb     = (put_refs_dec == '0) && put_dirty;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == CW'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (ric_cmd_t'(s_tuser) == CMD_GET)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (bad_idx)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_PUT_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (!hit_now && free_any)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_PUT_RD:
            begin
                state_next = ST_PUT_EVAL;
            end
            ST_PUT_EVAL:
            begin
                state_next = (cur_used && put_wb) ? ST_DIV : ST_RESP;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (resp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we       = 1'b0;
        ram_waddr    = cnt_reg[SW-1:0];
        ram_wdata    = '0;
        ram_raddr    = cnt_reg[SW-1:0];
        div_start    = 1'b0;
        div_dividend = ino_reg - INO_W'(1);
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_SCAN:
            begin
                if (hit_now)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg;
                    ram_wdata = '{dev: cur.dev, ino: cur.ino, refs: hit_refs, dirty: cur.dirty};
                end
                else if (scan_end && free_any)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = free_slot;
                    ram_wdata = '{dev: dev_reg, ino: ino_reg, refs: REFS_W'(1), dirty: 1'b0};
                    div_start = 1'b1;
                end
            end
            ST_PUT_RD:
            begin
                ram_raddr = SW'(idx_reg);
            end
            ST_PUT_EVAL:
            begin
                if (cur_used)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = SW'(idx_reg);
                    ram_wdata    = '{dev: cur.dev, ino: cur.ino, refs: put_refs_fin,
                                     dirty: put_wdirty};
                    div_start    = put_wb;
                    div_dividend = cur.ino - INO_W'(1);
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            scan_pend_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            root_dev_reg   <= ROOT_DEV_RESET;
            root_ino_reg   <= ROOT_INO_RESET;
        end
        else
        begin
            state_reg <= state_next;

            case (state_reg)
                ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                ST_IDLE:
                begin
                    cnt_reg        <= '0;
                    scan_pend_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    scan_pend_reg <= (cnt_reg < CW'(SLOTS));
                    if (cnt_reg < CW'(SLOTS))
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (free_now)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
                default:
                begin
                    scan_pend_reg <= 1'b0;
                end
            endcase

            m_valid_reg <= resp_load || (m_valid_reg && !m_tready);

            if (cfg_valid && cfg_ready)
            begin
                case (ric_cfg_t'(cfg_index))
                    CFG_ROOT_DEVICE: root_dev_reg <= cfg_data[DEV_W-1:0];
                    CFG_ROOT_INODE:  root_ino_reg <= cfg_data[INO_W-1:0];
                    default:         root_ino_reg <= root_ino_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    dev_reg        <= s_dev;
                    ino_reg        <= s_ino;
                    idx_reg        <= s_idx;
                    mod_reg        <= s_mod;
                    table_reg      <= s_table;
                    res_status_reg <= STAT_BAD_SLOT;
                    res_slot_reg   <= s_idx;
                    res_blk_reg    <= '0;
                    res_off_reg    <= '0;
                    res_refs_reg   <= '0;
                end
            end
            ST_SCAN:
            begin
                pend_addr_reg <= cnt_reg[SW-1:0];
                if (free_now)
                begin
                    free_slot_reg <= pend_addr_reg;
                end
                if (hit_now)
                begin
                    res_status_reg <= STAT_HIT;
                    res_slot_reg   <= IDX_W'(pend_addr_reg);
                    res_refs_reg   <= hit_refs;
                end
                else if (scan_end)
                begin
                    if (free_any)
                    begin
                        res_status_reg <= STAT_LOADED;
                        res_slot_reg   <= IDX_W'(free_slot);
                        res_refs_reg   <= REFS_W'(1);
                    end
                    else
                    begin
                        res_status_reg <= STAT_FULL;
                        res_slot_reg   <= '0;
                        res_refs_reg   <= '0;
                    end
                end
            end
            ST_PUT_EVAL:
            begin
                res_slot_reg <= idx_reg;
                if (!cur_used)
                begin
                    res_status_reg <= STAT_BAD_SLOT;
                    res_refs_reg   <= '0;
                end
                else
                begin
                    res_status_reg <= (put_refs_dec == '0 && put_dirty) ? STAT_WRITEBACK
                                                                        : STAT_RELEASED;
                    res_refs_reg   <= put_refs_fin;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_blk_reg <= div_q + table_reg;
                    res_off_reg <= OFF_W'(div_rem);
                end
            end
            default:
            begin
            end
        endcase

        if (resp_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_blk_reg    <= res_blk_reg;
            out_off_reg    <= res_off_reg;
            out_refs_reg   <= res_refs_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, out_refs_reg, out_off_reg, out_blk_reg, out_slot_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

>>> test/inode_cache_monitor.sv
`timescale 1ns / 100ps
// Inode cache monitor: tracks the slot table, predicts each command's result and compares beats.
module inode_cache_monitor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [ric_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ric_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [ric_pkg::STAT_W-1:0]    m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [ric_pkg::CFG_W-1:0]     cfg_data,
    output int                            failures,
    output int                            outstanding
);

    import ric_pkg::*;

    localparam int                 SLOTS     = SLOTS_DEFAULT;
    localparam logic [INO_W-1:0]   PER_BLOCK = IPB_DEFAULT;

    typedef struct packed
    {
        ric_status_t       status;
        logic [IDX_W-1:0]  slot;
        logic [BLK_W-1:0]  blk;
        logic [OFF_W-1:0]  off;
        logic [REFS_W-1:0] refs;
    } cache_reply_t;

    logic [DEV_W-1:0]  line_dev   [SLOTS];
    logic [INO_W-1:0]  line_ino   [SLOTS];
    logic [REFS_W-1:0] line_refs  [SLOTS];
    logic              line_dirty [SLOTS];
    logic [DEV_W-1:0]  root_dev;
    logic [INO_W-1:0]  root_ino;

    cache_reply_t awaited_replies[$];
    int           fault_count = 0;

    assign failures = fault_count;

    function automatic cache_reply_t serve_command(input ric_cmd_t         cmd,
                                                   input logic [DEV_W-1:0] dev,
                                                   input logic [INO_W-1:0] ino,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic             modified,
                                                   input logic [BLK_W-1:0] tbl);
        cache_reply_t     reply;
        int               found;
        logic [INO_W-1:0] k;
        reply = '0;
        found = -1;
        if (cmd == CMD_GET)
        begin
            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && line_refs[i] != 0 && line_dev[i] == dev && line_ino[i] == ino)
                    found = i;
            if (found >= 0)
            begin
                if (line_refs[found] != REFS_MAX)
                    line_refs[found] = line_refs[found] + REFS_W'(1);
                reply.status = STAT_HIT;
                reply.slot   = IDX_W'(found);
                reply.refs   = line_refs[found];
                return reply;
            end
            for (int i = 0; i < SLOTS; i++)
                if (found < 0 && line_refs[i] == 0)
                    found = i;
            if (found < 0)
            begin
                reply.status = STAT_FULL;
                return reply;
            end
            line_dev[found]   = dev;
            line_ino[found]   = ino;
            line_refs[found]  = REFS_W'(1);
            line_dirty[found] = 1'b0;
            k = ino - INO_W'(1);
            reply.status = STAT_LOADED;
            reply.slot   = IDX_W'(found);
            reply.blk    = k / PER_BLOCK + tbl;
            reply.off    = OFF_W'(k % PER_BLOCK);
            reply.refs   = REFS_W'(1);
            return reply;
        end
        reply.slot = idx;
        if (int'(idx) >= SLOTS || line_refs[idx] == 0)
        begin
            reply.status = STAT_BAD_SLOT;
            return reply;
        end
        line_dirty[idx] = line_dirty[idx] | modified;
        line_refs[idx]  = line_refs[idx] - REFS_W'(1);
        reply.status    = STAT_RELEASED;
        if (line_refs[idx] == 0)
        begin
            if (line_dev[idx] == root_dev && line_ino[idx] == root_ino)
                line_refs[idx] = REFS_W'(1);
            if (line_dirty[idx])
            begin
                line_dirty[idx] = 1'b0;
                k = line_ino[idx] - INO_W'(1);
                reply.status = STAT_WRITEBACK;
                reply.blk    = k / PER_BLOCK + tbl;
                reply.off    = OFF_W'(k % PER_BLOCK);
            end
        end
        reply.refs = line_refs[idx];
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cache_reply_t want;
        cache_reply_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                line_dev[i]   = '0;
                line_ino[i]   = '0;
                line_refs[i]  = '0;
                line_dirty[i] = 1'b0;
            end
            root_dev = ROOT_DEV_RESET;
            root_ino = ROOT_INO_RESET;
            awaited_replies.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ROOT_DEVICE)
                    root_dev = cfg_data[DEV_W-1:0];
                else
                    root_ino = cfg_data[INO_W-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                got.status = ric_status_t'(m_tuser);
                got.slot   = m_tdata[5:0];
                got.blk    = m_tdata[37:6];
                got.off    = m_tdata[40:38];
                got.refs   = m_tdata[56:41];
                if (awaited_replies.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("%0t: unexpected result beat: status %0d slot %0d block %h",
                                 $realtime, got.status, got.slot, got.blk);
                    fault_count++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status || got.slot !== want.slot
                        || got.blk !== want.blk || got.off !== want.off
                        || got.refs !== want.refs)
                    begin
                        if (fault_count < 10)
                        begin
                            $display("%0t: expected st %0d slot %0d blk %h off %0d refs %0d",
                                     $realtime, want.status, want.slot, want.blk, want.off,
                                     want.refs);
                            $display("%0t:      got st %0d slot %0d blk %h off %0d refs %0d",
                                     $realtime, got.status, got.slot, got.blk, got.off,
                                     got.refs);
                        end
                        fault_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_replies.push_back(serve_command(ric_cmd_t'(s_tuser), s_tdata[3:0],
                                                        s_tdata[35:4], s_tdata[41:36],
                                                        s_tdata[42], s_tdata[74:43]));
            outstanding <= awaited_replies.size();
        end
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Testbench top: drives get and put commands and root writes into the inode cache, gives the verdict.
module testbench;
    import ric_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_ITEMS  = 200;
    localparam int FILL_GETS    = 72;
    localparam int POOL_KEYS    = 10;
    localparam int DRAIN_CYCLES = 200;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = 1'b0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    int                   failures;
    int                   outstanding;

    int                   issued    = 0;
    logic                 tx_brisk  = 1'b0;
    logic                 rx_brisk  = 1'b0;
    logic                 tracking  = 1'b0;
    logic [IDX_W-1:0]     held_slots[$];
    logic [DEV_W-1:0]     pool_dev[POOL_KEYS];
    logic [INO_W-1:0]     pool_ino[POOL_KEYS];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    refcounted_inode_cache_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    inode_cache_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    function automatic logic [INO_W-1:0] odd_inode();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 1;
            2:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue(input ric_cmd_t cmd, input logic [DEV_W-1:0] dev,
                         input logic [INO_W-1:0] ino, input logic [IDX_W-1:0] idx,
                         input logic modified, input logic [BLK_W-1:0] tbl);
        int gap;
        gap = tx_brisk ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, tbl, modified, idx, ino, dev};
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        issued++;
    endtask

    task automatic get_inode(input logic [DEV_W-1:0] dev, input logic [INO_W-1:0] ino,
                             input logic [BLK_W-1:0] tbl);
        issue(CMD_GET, dev, ino, IDX_W'($urandom), 1'($urandom), tbl);
    endtask

    task automatic put_inode(input logic [IDX_W-1:0] idx, input logic modified);
        issue(CMD_PUT, DEV_W'($urandom), INO_W'($urandom), idx, modified, $urandom);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_root(input logic [DEV_W-1:0] dev, input logic [INO_W-1:0] ino);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ROOT_DEVICE;
        cfg_data  <= {28'($urandom), dev};
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= CFG_ROOT_INODE;
        cfg_data  <= ino;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // release result beats after a drawn stall; note every reference handed out while tracking
    initial
    begin : result_sink
        int stall;
        forever
        begin
            stall = rx_brisk ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if (tracking && (m_tuser == STAT_HIT || m_tuser == STAT_LOADED))
                held_slots.push_back(m_tdata[5:0]);
            if ($urandom_range(0, 39) == 0)
                rx_brisk = !rx_brisk;
        end
    end

    initial
    begin : watchdog
        for (int cycle = 0; cycle < LIMIT_CYCLES; cycle++)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int               base;
        int               phase;
        int               pick;
        int               j;
        logic [IDX_W-1:0] idx;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        get_inode(4'd0, 32'd2, 32'd0);
        get_inode(4'd0, 32'd2, 32'd0);
        get_inode(4'd15, '1, '1);
        get_inode(4'd3, 32'd0, 32'd5);
        get_inode(4'd0, 32'd1, 32'd0);
        put_inode(6'd0, 1'b0);
        put_inode(6'd0, 1'b1);
        put_inode(6'd0, 1'b0);
        put_inode(6'd1, 1'b1);
        put_inode(6'd1, 1'b0);
        put_inode(6'd63, 1'b1);
        put_inode(6'd2, 1'b1);
        get_inode(4'd15, '1, 32'h8000_0000);
        settle();
        set_root(4'd15, '1);
        put_inode(6'd1, 1'b1);
        get_inode(4'd15, '1, 32'h0000_FFFF);
        put_inode(6'd3, 1'b0);
        settle();
        set_root(4'd0, 32'd1);

        tracking = 1'b1;
        base     = issued;
        phase    = 0;
        while (issued - base < RANDOM_ITEMS)
        begin
            for (int k = 0; k < POOL_KEYS; k++)
                if (phase == 0 || $urandom_range(0, 1) == 0)
                begin
                    pool_dev[k] = DEV_W'($urandom);
                    pool_ino[k] = odd_inode();
                end
            case ($urandom_range(0, 3))
                0:       set_root(4'd0, 32'd0);
                1:       set_root(4'd15, '1);
                2:       set_root(DEV_W'($urandom), odd_inode());
                default:
                begin
                    pick = $urandom_range(0, POOL_KEYS - 1);
                    set_root(pool_dev[pick], pool_ino[pick]);
                end
            endcase
            tx_brisk = ($urandom_range(0, 3) == 0);
            if (phase % 3 == 2)
            begin
                // fill the table past full, then hand every reference back
                repeat (FILL_GETS) get_inode(DEV_W'($urandom), odd_inode(), $urandom);
                settle();
                while (held_slots.size() != 0)
                begin
                    j   = $urandom_range(0, held_slots.size() - 1);
                    idx = held_slots[j];
                    held_slots.delete(j);
                    put_inode(idx, 1'($urandom));
                end
            end
            else
            begin
                repeat (PHASE_ITEMS)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 30 || (pick < 85 && pick >= 45 && held_slots.size() == 0))
                    begin
                        j = $urandom_range(0, POOL_KEYS - 1);
                        get_inode(pool_dev[j], pool_ino[j], $urandom);
                    end
                    else if (pick < 45)
                        get_inode(DEV_W'($urandom), odd_inode(), $urandom);
                    else if (pick < 85)
                    begin
                        j   = $urandom_range(0, held_slots.size() - 1);
                        idx = held_slots[j];
                        held_slots.delete(j);
                        put_inode(idx, 1'($urandom));
                    end
                    else
                        put_inode(IDX_W'($urandom), 1'($urandom));
                end
            end
            settle();
            phase++;
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
